>>> rtl/lpi_pkg.sv
// Package for the line/plane intersection unit: widths, pipeline payload
// types and the saturation helper. No dependencies.
`default_nettype none
package lpi_pkg;

  localparam int FRAC = 16;   // fraction bits of the Q16.16 format
  localparam int DW   = 54;   // signed plane distance width
  localparam int MW   = 54;   // unsigned magnitude width (distances, divisor)
  localparam int QB   = 34;   // quotient bits below the cap
  localparam int NL   = 27;   // low half of the multiplier split
  localparam int NW   = 87;   // full product width
  localparam int EW   = 17;   // epsilon register width
  localparam logic [EW-1:0] EPS_RESET = EW'(66);

  localparam logic MODE_RAY = 1'b0;
  localparam logic MODE_SEG = 1'b1;

  // per-coordinate payload from classification to the output
  typedef struct packed {
    logic               neg;    // scaled term is subtracted
    logic signed [33:0] base;   // point the scaled term is added to
    logic signed [31:0] mid;    // saturated midpoint
    logic               ovf;    // quotient hits the cap
    logic [MW-1:0]      rem;    // partial remainder
    logic [QB-1:0]      quot;   // partial quotient
    logic [QB-1:0]      nlow;   // dividend bits still to shift in
  } lpi_crd_t;

  typedef struct packed {
    logic              hit;
    logic              midsel;
    logic [MW-1:0]     den;
    lpi_crd_t [2:0]    c;
  } lpi_div_t;

  // clamp a 37-bit signed value into Q16.16 range
  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -37'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/lpi_in_if.sv
// Input channel of the line/plane intersection unit: valid/ready plus one
// query. Depends on nothing.
`default_nettype none
interface lpi_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] normal_x;
  logic signed [31:0] normal_y;
  logic signed [31:0] normal_z;
  logic signed [31:0] plane_offset;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic signed [31:0] second_z;
  modport source (output valid, mode, normal_x, normal_y, normal_z, plane_offset,
                  start_x, start_y, start_z, second_x, second_y, second_z,
                  input ready);
  modport sink (input valid, mode, normal_x, normal_y, normal_z, plane_offset,
                start_x, start_y, start_z, second_x, second_y, second_z,
                output ready);
endinterface
`default_nettype wire

>>> rtl/lpi_out_if.sv
// Result channel of the line/plane intersection unit: valid/ready plus hit
// flag and point. Depends on nothing.
`default_nettype none
interface lpi_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, hit, point_x, point_y, point_z, input ready);
  modport sink (input valid, hit, point_x, point_y, point_z, output ready);
endinterface
`default_nettype wire

>>> rtl/line_plane_intersection_unit.sv
// Line/plane intersection unit top level. Uses lpi_pkg, lpi_in_if, lpi_out_if.
//
// Takes one ray or segment query per transaction and returns one result per
// query, in order. From acceptance to the result register a query passes
// the stages for the dot products, classification and the split 33x54
// multiply, a divider setup stage, a restoring divider (one quotient bit per
// stage, three coordinates side by side) and the output register. A new query
// is taken every cycle unless the result channel holds the pipeline; each stage
// holds its own valid bit, so a stalled result register only stops the stages
// behind it once they are full. cfg_wdata sets the on-plane epsilon and may be
// written only while no query is in flight.
`default_nettype none
module line_plane_intersection_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  lpi_in_if.sink                in_ch,
  lpi_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [lpi_pkg::EW-1:0] cfg_wdata
);

  localparam int DW = lpi_pkg::DW;
  localparam int MW = lpi_pkg::MW;
  localparam int QB = lpi_pkg::QB;
  localparam int NL = lpi_pkg::NL;
  localparam int NW = lpi_pkg::NW;

  // epsilon register
  logic [lpi_pkg::EW-1:0] eps_r;
  always_ff @(posedge clk) begin
    if (!rst_n) eps_r <= lpi_pkg::EPS_RESET;
    else if (cfg_we) eps_r <= cfg_wdata;
  end

  // valid bits and ready chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_v_r;
  logic r1, r2, r3, r4, r5, r6, ro;
  logic dv_v_r [QB+1];
  logic rd [QB+1];

  assign ro = !out_v_r || out_ch.ready;
  assign rd[QB] = !dv_v_r[QB] || ro;
  for (genvar j = 0; j < QB; j++) begin : g_rdy
    assign rd[j] = !dv_v_r[j] || rd[j+1];
  end
  assign r6 = !v6_r || rd[0];
  assign r5 = !v5_r || r6;
  assign r4 = !v4_r || r5;
  assign r3 = !v3_r || r4;
  assign r2 = !v2_r || r3;
  assign r1 = !v1_r || r2;
  assign in_ch.ready = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; out_v_r <= 1'b0;
    end else begin
      if (r1) v1_r <= in_ch.valid;
      if (r2) v2_r <= v1_r;
      if (r3) v3_r <= v2_r;
      if (r4) v4_r <= v3_r;
      if (r5) v5_r <= v4_r;
      if (r6) v6_r <= v5_r;
      if (ro) out_v_r <= dv_v_r[QB];
    end
  end

  // stage 1: the six component products
  logic signed [63:0] pp1_r [3];
  logic signed [63:0] pq1_r [3];
  logic signed [31:0] p1_r [3];
  logic signed [31:0] q1_r [3];
  logic signed [31:0] off1_r;
  logic               mode1_r;
  logic signed [31:0] in_n [3];
  logic signed [31:0] in_p [3];
  logic signed [31:0] in_q [3];

  assign in_n[0] = in_ch.normal_x; assign in_n[1] = in_ch.normal_y;
  assign in_n[2] = in_ch.normal_z;
  assign in_p[0] = in_ch.start_x;  assign in_p[1] = in_ch.start_y;
  assign in_p[2] = in_ch.start_z;
  assign in_q[0] = in_ch.second_x; assign in_q[1] = in_ch.second_y;
  assign in_q[2] = in_ch.second_z;

  always_ff @(posedge clk) begin
    if (r1 && in_ch.valid) begin
      for (int i = 0; i < 3; i++) begin
        pp1_r[i] <= in_n[i] * in_p[i];
        pq1_r[i] <= in_n[i] * in_q[i];
        p1_r[i]  <= in_p[i];
        q1_r[i]  <= in_q[i];
      end
      off1_r  <= in_ch.plane_offset;
      mode1_r <= in_ch.mode;
    end
  end

  // stage 2: floor each product and sum the distances
  logic signed [DW-1:0] fd2_r, dq2_r, ts2_r;
  logic signed [31:0]   p2_r [3];
  logic signed [31:0]   q2_r [3];
  logic                 mode2_r;
  logic signed [DW-1:0] sp_nxt, sq_nxt;

  always_comb begin
    sp_nxt = '0;
    sq_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      sp_nxt = sp_nxt + DW'($signed(pp1_r[i][63:lpi_pkg::FRAC]));
      sq_nxt = sq_nxt + DW'($signed(pq1_r[i][63:lpi_pkg::FRAC]));
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && v1_r) begin
      fd2_r   <= sp_nxt + DW'(off1_r);
      dq2_r   <= sq_nxt;
      ts2_r   <= sq_nxt + DW'(off1_r);
      p2_r    <= p1_r;
      q2_r    <= q1_r;
      mode2_r <= mode1_r;
    end
  end

  // stage 3: end distance and end point
  logic signed [DW-1:0] fd3_r, td3_r, dn3_r;
  logic signed [31:0]   p3_r [3];
  logic signed [31:0]   q3_r [3];
  logic signed [33:0]   e3_r [3];
  logic                 mode3_r;

  always_ff @(posedge clk) begin
    if (r3 && v2_r) begin
      fd3_r   <= fd2_r;
      dn3_r   <= dq2_r;
      td3_r   <= (mode2_r == lpi_pkg::MODE_SEG) ? ts2_r : fd2_r + dq2_r;
      for (int i = 0; i < 3; i++) begin
        e3_r[i] <= (mode2_r == lpi_pkg::MODE_SEG) ? 34'(q2_r[i])
                                                  : 34'(p2_r[i]) + 34'(q2_r[i]);
      end
      p3_r    <= p2_r;
      q3_r    <= q2_r;
      mode3_r <= mode2_r;
    end
  end

  // stage 4: classify, pick base, scaled vector, numerator and divisor
  logic [MW-1:0]      a4, b4, adn4, s4, num_nxt;
  logic               ss4, rayss4;
  lpi_pkg::lpi_div_t  st4_nxt;
  logic [32:0]        vmag_nxt [3];
  logic signed [33:0] vv4;
  logic signed [33:0] pe4;
  logic [MW-1:0]      num4_r;
  logic [32:0]        vmag4_r [3];
  lpi_pkg::lpi_div_t  st4_r;

  always_comb begin
    a4   = MW'(fd3_r < 0 ? -fd3_r : fd3_r);
    b4   = MW'(td3_r < 0 ? -td3_r : td3_r);
    adn4 = MW'(dn3_r < 0 ? -dn3_r : dn3_r);
    s4   = a4 + b4;
    ss4  = (fd3_r > 0 && td3_r > 0) || (fd3_r < 0 && td3_r < 0);
    rayss4 = (mode3_r == lpi_pkg::MODE_RAY) && ss4;
    st4_nxt = '0;
    st4_nxt.hit = (mode3_r == lpi_pkg::MODE_RAY) ? (dn3_r != 0) : !ss4;
    st4_nxt.midsel = !rayss4 && ((s4 == '0) || (s4 < MW'(eps_r)));
    st4_nxt.den = rayss4 ? adn4 : s4;
    num_nxt = (rayss4 && !(a4 < b4)) ? b4 : a4;
    for (int i = 0; i < 3; i++) begin
      if (rayss4 && (a4 < b4)) begin
        vv4 = -34'(q3_r[i]);
        st4_nxt.c[i].base = 34'(p3_r[i]);
      end else if (rayss4) begin
        vv4 = 34'(q3_r[i]);
        st4_nxt.c[i].base = e3_r[i];
      end else begin
        vv4 = e3_r[i] - 34'(p3_r[i]);
        st4_nxt.c[i].base = 34'(p3_r[i]);
      end
      st4_nxt.c[i].neg = vv4 < 0;
      vmag_nxt[i] = 33'(vv4 < 0 ? -vv4 : vv4);
      pe4 = 34'(p3_r[i]) + e3_r[i];
      st4_nxt.c[i].mid = lpi_pkg::sat32(37'(pe4 >>> 1));
    end
  end

  always_ff @(posedge clk) begin
    if (r4 && v3_r) begin
      st4_r   <= st4_nxt;
      num4_r  <= num_nxt;
      vmag4_r <= vmag_nxt;
    end
  end

  // stage 5: partial products of |v| * numerator
  logic [59:0]       pl5_r [3];
  logic [59:0]       ph5_r [3];
  lpi_pkg::lpi_div_t st5_r;

  always_ff @(posedge clk) begin
    if (r5 && v4_r) begin
      for (int i = 0; i < 3; i++) begin
        pl5_r[i] <= 60'(vmag4_r[i]) * 60'(num4_r[NL-1:0]);
        ph5_r[i] <= 60'(vmag4_r[i]) * 60'(num4_r[MW-1:NL]);
      end
      st5_r <= st4_r;
    end
  end

  // stage 6: full dividend
  logic [NW-1:0]     n6_r [3];
  lpi_pkg::lpi_div_t st6_r;

  always_ff @(posedge clk) begin
    if (r6 && v5_r) begin
      for (int i = 0; i < 3; i++) begin
        n6_r[i] <= NW'(pl5_r[i]) + (NW'(ph5_r[i]) << NL);
      end
      st6_r <= st5_r;
    end
  end

  // divider setup: cap check and initial remainder
  lpi_pkg::lpi_div_t dv_r   [QB+1];
  lpi_pkg::lpi_div_t dv_nxt [QB+1];

  always_comb begin
    dv_nxt[0] = st6_r;
    for (int i = 0; i < 3; i++) begin
      dv_nxt[0].c[i].ovf  = MW'(n6_r[i][NW-1:QB]) >= st6_r.den;
      dv_nxt[0].c[i].rem  = MW'(n6_r[i][NW-1:QB]);
      dv_nxt[0].c[i].quot = '0;
      dv_nxt[0].c[i].nlow = n6_r[i][QB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (rd[0]) dv_v_r[0] <= v6_r;
  end
  always_ff @(posedge clk) begin
    if (rd[0] && v6_r) dv_r[0] <= dv_nxt[0];
  end

  // restoring divider: one quotient bit per stage
  for (genvar j = 1; j <= QB; j++) begin : g_div
    logic [MW:0] trial;
    logic        ge;
    always_comb begin
      dv_nxt[j] = dv_r[j-1];
      trial = '0;
      ge = 1'b0;
      for (int i = 0; i < 3; i++) begin
        trial = {dv_r[j-1].c[i].rem, dv_r[j-1].c[i].nlow[QB-j]};
        ge = trial >= {1'b0, dv_r[j-1].den};
        dv_nxt[j].c[i].rem  = ge ? MW'(trial - {1'b0, dv_r[j-1].den}) : MW'(trial);
        dv_nxt[j].c[i].quot = {dv_r[j-1].c[i].quot[QB-2:0], ge};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[j] <= 1'b0;
      else if (rd[j]) dv_v_r[j] <= dv_v_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (rd[j] && dv_v_r[j-1]) dv_r[j] <= dv_nxt[j];
    end
  end

  // output: apply sign, add to base, saturate; a miss gives zero, midsel the midpoint
  logic               hit_r;
  logic signed [31:0] pt_r [3];
  logic signed [31:0] pt_nxt [3];
  logic [QB:0]        qc;
  logic signed [36:0] term, sum;

  always_comb begin
    qc = '0; term = '0; sum = '0;
    for (int i = 0; i < 3; i++) begin
      qc = dv_r[QB].c[i].ovf ? (QB+1)'(1) << QB : {1'b0, dv_r[QB].c[i].quot};
      term = dv_r[QB].c[i].neg ? -37'(qc) : 37'(qc);
      sum = 37'(dv_r[QB].c[i].base) + term;
      if (!dv_r[QB].hit) pt_nxt[i] = '0;
      else if (dv_r[QB].midsel) pt_nxt[i] = dv_r[QB].c[i].mid;
      else pt_nxt[i] = lpi_pkg::sat32(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (ro && dv_v_r[QB]) begin
      hit_r <= dv_r[QB].hit;
      pt_r  <= pt_nxt;
    end
  end

  assign out_ch.valid   = out_v_r;
  assign out_ch.hit     = hit_r;
  assign out_ch.point_x = pt_r[0];
  assign out_ch.point_y = pt_r[1];
  assign out_ch.point_z = pt_r[2];

  // a miss always reports the origin
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.hit |->
      out_ch.point_x == 0 && out_ch.point_y == 0 && out_ch.point_z == 0)
    else $error("miss with nonzero point");

  // an accepted transaction always lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v1_r)
    else $error("accepted transaction lost at entry");

  // a full last divider stage drains when the result register frees
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    dv_v_r[QB] && ro |=> out_v_r)
    else $error("divider result not moved to output");

endmodule
`default_nettype wire

>>> verif/tb_line_plane_intersection_unit.sv
// Self-checking testbench for line_plane_intersection_unit.
// Depends on lpi_pkg, lpi_in_if and lpi_out_if from the RTL; runs directed
// and random ray/segment queries against its own predictor of the unit.
`default_nettype none
module tb_line_plane_intersection_unit;

  localparam int  EW         = lpi_pkg::EW;
  localparam int  FRAC       = lpi_pkg::FRAC;
  localparam int  LATENCY    = 42;
  localparam int  DRAIN      = LATENCY + 8;
  localparam int  CYCLE_CAP  = 400000;
  localparam int  RAND_ITEMS = 1250;
  localparam logic [127:0] SCALE_CAP = 128'd1 << 62;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] nx, ny, nz, off;
    logic signed [31:0] px, py, pz;
    logic signed [31:0] sx, sy, sz;
  } query_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] x, y, z;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [EW-1:0] cfg_wdata = '0;

  lpi_in_if  in_ch ();
  lpi_out_if out_ch ();

  line_plane_intersection_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock, period 20
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  query_t       pending_queries[$];
  point_t       expected_points[$];
  logic [EW-1:0] epsilon_model = lpi_pkg::EPS_RESET;
  logic         sender_hold = 1'b0;
  logic         no_idle = 1'b0;
  int           mismatches = 0;
  int           checked = 0;
  int           hits_seen = 0;
  int           cycles = 0;

  // |v|*num/den truncated toward zero, magnitude capped at 2^62
  function automatic longint scale_term(longint v, logic [63:0] num, logic [63:0] den);
    logic [63:0]  mag;
    logic [127:0] prod;
    logic [127:0] quo;
    mag = v < 0 ? 64'(-v) : 64'(v);
    prod = 128'(mag) * 128'(num);
    if (den == 0 || prod[127:64] >= den) quo = SCALE_CAP;
    else quo = prod / 128'(den);
    if (quo > SCALE_CAP) quo = SCALE_CAP;
    return v < 0 ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint plane_dot(longint n[3], longint v[3]);
    longint acc;
    acc = 0;
    for (int i = 0; i < 3; i++) acc += (n[i] * v[i]) >>> FRAC;
    return acc;
  endfunction

  function automatic logic [63:0] mag64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // expected result of one query under the given epsilon
  function automatic point_t intersect_query(query_t q, logic [EW-1:0] eps);
    longint n[3], p[3], v[3], e[3], r[3];
    longint fd, td, dn;
    logic [63:0] a, b, s, adn;
    logic hit;
    point_t res;
    n = '{longint'(q.nx), longint'(q.ny), longint'(q.nz)};
    p = '{longint'(q.px), longint'(q.py), longint'(q.pz)};
    v = '{longint'(q.sx), longint'(q.sy), longint'(q.sz)};
    r = '{0, 0, 0};
    hit = 1'b1;
    fd = plane_dot(n, p) + longint'(q.off);
    if (q.mode == lpi_pkg::MODE_RAY) begin
      dn = plane_dot(n, v);
      for (int i = 0; i < 3; i++) e[i] = p[i] + v[i];
      td = fd + dn;
    end else begin
      dn = 1;
      e = v;
      td = plane_dot(n, v) + longint'(q.off);
    end
    a = mag64(fd);
    b = mag64(td);
    s = a + b;
    adn = mag64(dn);
    if (q.mode == lpi_pkg::MODE_RAY && dn == 0) begin
      hit = 1'b0;
    end else if ((fd > 0 && td > 0) || (fd < 0 && td < 0)) begin
      // same side: segments miss, rays extend to the plane
      if (q.mode == lpi_pkg::MODE_SEG) hit = 1'b0;
      else for (int i = 0; i < 3; i++) begin
        if (a < b) r[i] = p[i] - scale_term(v[i], a, adn);
        else r[i] = e[i] + scale_term(v[i], b, adn);
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (s == 0 || s < 64'(eps)) r[i] = (p[i] + e[i]) >>> 1;
        else r[i] = p[i] + scale_term(e[i] - p[i], a, s);
      end
    end
    res.hit = hit;
    res.x = hit ? clamp32(r[0]) : '0;
    res.y = hit ? clamp32(r[1]) : '0;
    res.z = hit ? clamp32(r[2]) : '0;
    return res;
  endfunction

  // driver: predict on acceptance, then present the next query
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_points.push_back(intersect_query({in_ch.mode, in_ch.normal_x,
          in_ch.normal_y, in_ch.normal_z, in_ch.plane_offset, in_ch.start_x,
          in_ch.start_y, in_ch.start_z, in_ch.second_x, in_ch.second_y,
          in_ch.second_z}, epsilon_model));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_queries.size() > 0 && !sender_hold &&
            (no_idle || $urandom_range(99) >= 27)) begin
          query_t q;
          q = pending_queries.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.mode         <= q.mode;
          in_ch.normal_x     <= q.nx;
          in_ch.normal_y     <= q.ny;
          in_ch.normal_z     <= q.nz;
          in_ch.plane_offset <= q.off;
          in_ch.start_x      <= q.px;
          in_ch.start_y      <= q.py;
          in_ch.start_z      <= q.pz;
          in_ch.second_x     <= q.sx;
          in_ch.second_y     <= q.sy;
          in_ch.second_z     <= q.sz;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        point_t got, want;
        got = {out_ch.hit, out_ch.point_x, out_ch.point_y, out_ch.point_z};
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result hit=%0b (%0d,%0d,%0d)",
                                         got.hit, got.x, got.y, got.z);
        end else begin
          want = expected_points.pop_front();
          checked++;
          if (got.hit) hits_seen++;
          if (got.hit !== want.hit || got.x !== want.x || got.y !== want.y ||
              got.z !== want.z) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch #%0d: exp hit=%0b (%0d,%0d,%0d) got hit=%0b (%0d,%0d,%0d)",
                       checked, want.hit, want.x, want.y, want.z,
                       got.hit, got.x, got.y, got.z);
          end
        end
      end
      out_ch.ready <= no_idle || $urandom_range(99) >= 27;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("line_plane_intersection_unit regression: fail");
      $finish;
    end
  end

  function automatic query_t mk(logic m, int nx, int ny, int nz, int off,
                                int px, int py, int pz, int sx, int sy, int sz);
    return {m, nx, ny, nz, off, px, py, pz, sx, sy, sz};
  endfunction

  // signed value within +/- units in Q16.16
  function automatic int near_val(int units);
    return $signed($urandom_range(2 * units * 65536)) - units * 65536;
  endfunction

  function automatic query_t random_query();
    query_t q;
    int kind;
    kind = $urandom_range(9);
    q.mode = 1'($urandom_range(1));
    if (kind <= 1) begin
      // full-range noise
      q = {1'($urandom_range(1)), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    end else if (kind == 2) begin
      // ray parallel to an axis plane
      q = mk(lpi_pkg::MODE_RAY, near_val(4), 0, 0, near_val(50), near_val(50),
             near_val(50), near_val(50), 0, near_val(50), near_val(50));
    end else if (kind == 3) begin
      // endpoints within a hair of the plane x = c
      int c;
      c = near_val(100);
      q = mk(lpi_pkg::MODE_SEG, 65536, 0, 0, -c,
             c + near_val(0) + $signed($urandom_range(80)) - 40,
             near_val(100), near_val(100), c + $signed($urandom_range(80)) - 40,
             near_val(100), near_val(100));
    end else if (kind == 4) begin
      // far intersections with a grazing direction
      q = mk(q.mode, $urandom_range(3), near_val(2), near_val(2), $urandom(),
             $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    end else begin
      q = mk(q.mode, near_val(2), near_val(2), near_val(2), near_val(200),
             near_val(200), near_val(200), near_val(200),
             near_val(200), near_val(200), near_val(200));
    end
    return q;
  endfunction

  task automatic wait_drained();
    while (pending_queries.size() > 0 || in_ch.valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_epsilon(logic [EW-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    epsilon_model = v;
  endtask

  logic [EW-1:0] eps_plan[6] = '{EW'(0), EW'(65536), EW'(1), EW'(66), EW'(4000), EW'(200)};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    {in_ch.normal_x, in_ch.normal_y, in_ch.normal_z, in_ch.plane_offset} = '0;
    {in_ch.start_x, in_ch.start_y, in_ch.start_z} = '0;
    {in_ch.second_x, in_ch.second_y, in_ch.second_z} = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed cases under the reset epsilon
    pending_queries.push_back(mk(lpi_pkg::MODE_SEG, 65536, 0, 0, 0,
                                 -65536, 5, 6, 65536, 7, 8));
    pending_queries.push_back(mk(lpi_pkg::MODE_SEG, 65536, 0, 0, 0,
                                 65536, 0, 0, 131072, 0, 0));
    pending_queries.push_back(mk(lpi_pkg::MODE_SEG, 65536, 0, 0, 0,
                                 -65536, 0, 0, -3, 0, 0));
    pending_queries.push_back(mk(lpi_pkg::MODE_SEG, 0, 0, 0, 0,
                                 10, -11, 12, 13, 14, -15));
    pending_queries.push_back(mk(lpi_pkg::MODE_SEG, 65536, 0, 0, 0,
                                 20, 3, 3, -20, 5, -7));
    pending_queries.push_back(mk(lpi_pkg::MODE_RAY, 65536, 0, 0, 0,
                                 65536, 0, 0, 0, 65536, 0));
    pending_queries.push_back(mk(lpi_pkg::MODE_RAY, 65536, 0, 0, 0,
                                 65536, 1, 2, 65536, 3, 4));
    pending_queries.push_back(mk(lpi_pkg::MODE_RAY, 65536, 0, 0, 0,
                                 196608, 1, 2, -65536, 3, 4));
    pending_queries.push_back(mk(lpi_pkg::MODE_RAY, 65536, 0, 0, 0,
                                 -65536, 7, 9, 131072, 1, 1));
    pending_queries.push_back(mk(lpi_pkg::MODE_RAY, 65536, 0, 0, 0,
                                 65536, 0, 0, 1, 65536, 65536));
    pending_queries.push_back(mk(lpi_pkg::MODE_RAY, 1, 0, 0, 0,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                 1, 32'h7FFF_FFFF, 32'h8000_0000));
    pending_queries.push_back(mk(lpi_pkg::MODE_SEG, 32'h8000_0000, 32'h8000_0000,
                                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_queries.push_back(mk(lpi_pkg::MODE_RAY, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                 32'h8000_0000, 32'h8000_0000));
    pending_queries.push_back(mk(lpi_pkg::MODE_SEG, 0, 0, 0, 0,
                                 32'h7FFF_FFFF, 32'h8000_0000, -1,
                                 32'h7FFF_FFFF, 32'h8000_0000, -1));
    pending_queries.push_back(mk(lpi_pkg::MODE_RAY, -1, -1, -1, -1,
                                 -1, -1, -1, -1, -1, -1));
    pending_queries.push_back(mk(lpi_pkg::MODE_SEG, 65536, 0, 0, 0,
                                 0, 1, 2, 0, 3, 4));
    wait_drained();

    // random phases, each under its own epsilon; sender waits for drain between
    for (int ph = 0; ph < 6; ph++) begin
      set_epsilon(eps_plan[ph]);
      no_idle = (ph == 2);
      for (int k = 0; k < RAND_ITEMS / 6; k++) pending_queries.push_back(random_query());
      wait_drained();
    end
    no_idle = 1'b0;
    set_epsilon(EW'($urandom_range(65536)));
    for (int k = 0; k < 40; k++) pending_queries.push_back(random_query());
    wait_drained();

    $display("covered %0d queries (%0d hits) under 8 epsilon settings incl. 0 and 65536",
             checked, hits_seen);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("line_plane_intersection_unit regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("line_plane_intersection_unit regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
